### sv/tokscan_pkg.sv
// Package of the token scanner: scan modes, result codes and character helpers.
package tokscan_pkg;

  localparam int OFFSET_BITS_DEF   = 24;
  localparam int POSITION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH       = 4;

  typedef enum logic [3:0] {
    M_IDLE, M_DIRECTIVE, M_WORD, M_NUMBER, M_AFTERDOT,
    M_BADIDENT, M_STRING, M_ESCAPE, M_AMP, M_PLUS
  } scan_mode_t;

  localparam logic [3:0] K_KEYWORD  = 4'd0;
  localparam logic [3:0] K_BOOL     = 4'd1;
  localparam logic [3:0] K_IDENT    = 4'd2;
  localparam logic [3:0] K_INT      = 4'd3;
  localparam logic [3:0] K_FLOAT    = 4'd4;
  localparam logic [3:0] K_STRING   = 4'd5;
  localparam logic [3:0] K_OPERATOR = 4'd6;
  localparam logic [3:0] K_DELIM    = 4'd7;
  localparam logic [3:0] K_ERROR    = 4'd8;
  localparam logic [3:0] K_END      = 4'd9;

  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_DOT      = 3'd1;
  localparam logic [2:0] E_BADIDENT = 3'd2;
  localparam logic [2:0] E_UNCLOSED = 3'd3;
  localparam logic [2:0] E_UNKNOWN  = 3'd4;
  localparam logic [2:0] E_INVALID  = 3'd5;

  localparam logic [3:0] NO_WORD    = 4'd10;
  localparam logic [7:0] OP_ANDAND  = 8'd1;
  localparam logic [7:0] OP_PLUSPLUS = 8'd2;
  localparam logic [7:0] OP_NONE    = 8'd0;

  localparam logic [47:0] WORD_TEXT [10] = '{
    48'h696E74, 48'h63686172, 48'h72657475726E, 48'h6966, 48'h656C7365,
    48'h666F72, 48'h74727565, 48'h66616C7365, 48'h54727565, 48'h46616C7365
  };
  localparam logic [2:0] WORD_LEN [10] = '{3'd3, 3'd4, 3'd6, 3'd2, 3'd4,
                                            3'd3, 3'd4, 3'd5, 3'd4, 3'd5};

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic word_start(logic [7:0] c);
    return is_alpha(c) || c == "_";
  endfunction

  function automatic logic word_char(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  // Returns the keyword or boolean index, or NO_WORD.
  function automatic logic [3:0] word_lookup(logic [47:0] wbuf, logic [2:0] wlen);
    logic [3:0] idx;
    idx = NO_WORD;
    for (int w = 9; w >= 0; w--) begin
      if (WORD_LEN[w] == wlen && WORD_TEXT[w] == wbuf) idx = 4'(w);
    end
    return idx;
  endfunction

endpackage

### sv/tokscan_if.sv
// Stream interfaces of the token scanner: source bytes in, token results out.
interface tok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface tok_out_if #(
  parameter int OFFSET_BITS   = tokscan_pkg::OFFSET_BITS_DEF,
  parameter int POSITION_BITS = tokscan_pkg::POSITION_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [3:0]               token_kind;
  logic [2:0]               error_code;
  logic [3:0]               word_index;
  logic [7:0]               op_code;
  logic [OFFSET_BITS-1:0]   start_offset;
  logic [OFFSET_BITS-1:0]   lexeme_length;
  logic [POSITION_BITS-1:0] token_line;
  logic [POSITION_BITS-1:0] token_column;
  logic                     last_of_run;
  modport source (output valid, output token_kind, output error_code, output word_index,
                  output op_code, output start_offset, output lexeme_length,
                  output token_line, output token_column, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input error_code, input word_index,
                  input op_code, input start_offset, input lexeme_length,
                  input token_line, input token_column, input last_of_run,
                  output ready);
endinterface

### sv/tok_front.sv
// Front end: scans one byte per transfer and pushes the results it causes as a bundle.
module tok_front #(
  parameter int OFFSET_BITS   = tokscan_pkg::OFFSET_BITS_DEF,
  parameter int POSITION_BITS = tokscan_pkg::POSITION_BITS_DEF,
  localparam int RES_BITS     = 19 + 2*OFFSET_BITS + 2*POSITION_BITS,
  localparam int BUNDLE_BITS  = 2 + 3*RES_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take_i,
  input  logic [7:0]             byte_i,
  input  logic                   eot_i,
  output logic                   push_o,
  output logic [BUNDLE_BITS-1:0] bundle_o
);

  typedef struct packed {
    logic [3:0]               kind;
    logic [2:0]               err;
    logic [3:0]               word;
    logic [7:0]               op;
    logic [OFFSET_BITS-1:0]   off;
    logic [OFFSET_BITS-1:0]   len;
    logic [POSITION_BITS-1:0] line;
    logic [POSITION_BITS-1:0] col;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t [2:0] res;
  } bundle_t;

  localparam logic [OFFSET_BITS-1:0]   OFF_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  tokscan_pkg::scan_mode_t  mode_r, mode_nxt;
  logic                     dot_r, dot_nxt;
  logic [OFFSET_BITS-1:0]   off_r, off_nxt, tso_r, tso_nxt, tlen_r, tlen_nxt;
  logic [POSITION_BITS-1:0] line_r, line_nxt, col_r, col_nxt;
  logic [POSITION_BITS-1:0] tsl_r, tsl_nxt, tsc_r, tsc_nxt;
  logic [47:0]              wbuf_r, wbuf_nxt;
  logic [2:0]               wlen_r, wlen_nxt;

  res_t     cand [4];
  logic [2:0] n;
  bundle_t  bundle;

  always_comb begin
    logic absorbed;
    logic [7:0] c;
    c = byte_i;
    mode_nxt = mode_r;  dot_nxt = dot_r;   off_nxt = off_r;
    tso_nxt = tso_r;    tlen_nxt = tlen_r; line_nxt = line_r;
    col_nxt = col_r;    tsl_nxt = tsl_r;   tsc_nxt = tsc_r;
    wbuf_nxt = wbuf_r;  wlen_nxt = wlen_r;
    n = 3'd0;
    absorbed = 1'b0;
    for (int i = 0; i < 4; i++) cand[i] = '0;

    // Bytes that continue or close the open token.
    unique case (mode_r)
      tokscan_pkg::M_DIRECTIVE: begin
        if (c == 8'h0A) mode_nxt = tokscan_pkg::M_IDLE;
        else absorbed = 1'b1;
      end
      tokscan_pkg::M_WORD: begin
        if (tokscan_pkg::word_char(c)) begin
          absorbed = 1'b1;
          if (tlen_nxt < OFF_MAX) tlen_nxt = tlen_nxt + 1'b1;
          if (wlen_nxt < 3'd6) wbuf_nxt = {wbuf_nxt[39:0], c};
          if (wlen_nxt < 3'd7) wlen_nxt = wlen_nxt + 3'd1;
        end else begin
          cand[n[1:0]] = '{tokscan_pkg::word_lookup(wbuf_nxt, wlen_nxt) == tokscan_pkg::NO_WORD
                             ? tokscan_pkg::K_IDENT
                             : (tokscan_pkg::word_lookup(wbuf_nxt, wlen_nxt) < 4'd6
                                ? tokscan_pkg::K_KEYWORD : tokscan_pkg::K_BOOL),
                           tokscan_pkg::E_NONE, tokscan_pkg::word_lookup(wbuf_nxt, wlen_nxt),
                           tokscan_pkg::OP_NONE, tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
          n = n + 3'd1;
          mode_nxt = tokscan_pkg::M_IDLE;
        end
      end
      tokscan_pkg::M_NUMBER: begin
        if (tokscan_pkg::is_digit(c)) begin
          absorbed = 1'b1;
          if (tlen_nxt < OFF_MAX) tlen_nxt = tlen_nxt + 1'b1;
        end else if (c == ".") begin
          absorbed = 1'b1;
          if (tlen_nxt < OFF_MAX) tlen_nxt = tlen_nxt + 1'b1;
          if (dot_nxt) begin
            cand[n[1:0]] = '{tokscan_pkg::K_ERROR, tokscan_pkg::E_DOT, tokscan_pkg::NO_WORD,
                             tokscan_pkg::OP_NONE, tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
            n = n + 3'd1;
            mode_nxt = tokscan_pkg::M_AFTERDOT;
          end else begin
            dot_nxt = 1'b1;
          end
        end else if (tokscan_pkg::word_start(c)) begin
          absorbed = 1'b1;
          if (tlen_nxt < OFF_MAX) tlen_nxt = tlen_nxt + 1'b1;
          mode_nxt = tokscan_pkg::M_BADIDENT;
        end else begin
          cand[n[1:0]] = '{dot_nxt ? tokscan_pkg::K_FLOAT : tokscan_pkg::K_INT,
                           tokscan_pkg::E_NONE, tokscan_pkg::NO_WORD, tokscan_pkg::OP_NONE,
                           tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
          n = n + 3'd1;
          mode_nxt = tokscan_pkg::M_IDLE;
        end
      end
      tokscan_pkg::M_AFTERDOT: begin
        if (tokscan_pkg::word_start(c)) begin
          absorbed = 1'b1;
          if (tlen_nxt < OFF_MAX) tlen_nxt = tlen_nxt + 1'b1;
          mode_nxt = tokscan_pkg::M_BADIDENT;
        end else begin
          cand[n[1:0]] = '{tokscan_pkg::K_FLOAT, tokscan_pkg::E_NONE, tokscan_pkg::NO_WORD,
                           tokscan_pkg::OP_NONE, tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
          n = n + 3'd1;
          mode_nxt = tokscan_pkg::M_IDLE;
        end
      end
      tokscan_pkg::M_BADIDENT: begin
        if (tokscan_pkg::word_char(c)) begin
          absorbed = 1'b1;
          if (tlen_nxt < OFF_MAX) tlen_nxt = tlen_nxt + 1'b1;
        end else begin
          cand[n[1:0]] = '{tokscan_pkg::K_ERROR, tokscan_pkg::E_BADIDENT,
                           tokscan_pkg::NO_WORD, tokscan_pkg::OP_NONE,
                           tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
          n = n + 3'd1;
          mode_nxt = tokscan_pkg::M_IDLE;
        end
      end
      tokscan_pkg::M_STRING: begin
        absorbed = 1'b1;
        if (tlen_nxt < OFF_MAX) tlen_nxt = tlen_nxt + 1'b1;
        if (c == 8'h5C) begin
          mode_nxt = tokscan_pkg::M_ESCAPE;
        end else if (c == 8'h22) begin
          cand[n[1:0]] = '{tokscan_pkg::K_STRING, tokscan_pkg::E_NONE, tokscan_pkg::NO_WORD,
                           tokscan_pkg::OP_NONE, tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
          n = n + 3'd1;
          mode_nxt = tokscan_pkg::M_IDLE;
        end
      end
      tokscan_pkg::M_ESCAPE: begin
        absorbed = 1'b1;
        if (tlen_nxt < OFF_MAX) tlen_nxt = tlen_nxt + 1'b1;
        mode_nxt = tokscan_pkg::M_STRING;
      end
      tokscan_pkg::M_AMP: begin
        if (c == "&") begin
          absorbed = 1'b1;
          if (tlen_nxt < OFF_MAX) tlen_nxt = tlen_nxt + 1'b1;
          cand[n[1:0]] = '{tokscan_pkg::K_OPERATOR, tokscan_pkg::E_NONE,
                           tokscan_pkg::NO_WORD, tokscan_pkg::OP_ANDAND,
                           tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
        end else begin
          cand[n[1:0]] = '{tokscan_pkg::K_ERROR, tokscan_pkg::E_UNKNOWN,
                           tokscan_pkg::NO_WORD, 8'h26, tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
        end
        n = n + 3'd1;
        mode_nxt = tokscan_pkg::M_IDLE;
      end
      tokscan_pkg::M_PLUS: begin
        if (c == "+") begin
          absorbed = 1'b1;
          if (tlen_nxt < OFF_MAX) tlen_nxt = tlen_nxt + 1'b1;
          cand[n[1:0]] = '{tokscan_pkg::K_OPERATOR, tokscan_pkg::E_NONE,
                           tokscan_pkg::NO_WORD, tokscan_pkg::OP_PLUSPLUS,
                           tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
        end else begin
          cand[n[1:0]] = '{tokscan_pkg::K_OPERATOR, tokscan_pkg::E_NONE,
                           tokscan_pkg::NO_WORD, 8'h2B, tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
        end
        n = n + 3'd1;
        mode_nxt = tokscan_pkg::M_IDLE;
      end
      default: mode_nxt = tokscan_pkg::M_IDLE;
    endcase

    // A byte the open token did not take starts something new.
    if (!absorbed) begin
      tso_nxt = off_r;  tsl_nxt = line_r;  tsc_nxt = col_r;
      tlen_nxt = '0;    dot_nxt = 1'b0;    wbuf_nxt = '0;  wlen_nxt = '0;
      if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
        mode_nxt = tokscan_pkg::M_IDLE;
      end else if (c == "#") begin
        mode_nxt = tokscan_pkg::M_DIRECTIVE;
      end else begin
        tlen_nxt = OFFSET_BITS'(1);
        if (tokscan_pkg::word_start(c)) begin
          wbuf_nxt = {40'd0, c};
          wlen_nxt = 3'd1;
          mode_nxt = tokscan_pkg::M_WORD;
        end else if (tokscan_pkg::is_digit(c)) begin
          mode_nxt = tokscan_pkg::M_NUMBER;
        end else if (c == 8'h22) begin
          mode_nxt = tokscan_pkg::M_STRING;
        end else if (c == "&") begin
          mode_nxt = tokscan_pkg::M_AMP;
        end else if (c == "+") begin
          mode_nxt = tokscan_pkg::M_PLUS;
        end else begin
          mode_nxt = tokscan_pkg::M_IDLE;
          if (c == "=" || c == ">" || c == "<") begin
            cand[n[1:0]] = '{tokscan_pkg::K_OPERATOR, tokscan_pkg::E_NONE,
                             tokscan_pkg::NO_WORD, c, tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
          end else if (c == "|" || c == "!" || c == ":" || c == "%" || c == "^") begin
            cand[n[1:0]] = '{tokscan_pkg::K_ERROR, tokscan_pkg::E_UNKNOWN,
                             tokscan_pkg::NO_WORD, c, tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
          end else if (c == "(" || c == ")" || c == "{" || c == "}" || c == "[" ||
                       c == "]" || c == "," || c == ";") begin
            cand[n[1:0]] = '{tokscan_pkg::K_DELIM, tokscan_pkg::E_NONE,
                             tokscan_pkg::NO_WORD, c, tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
          end else begin
            cand[n[1:0]] = '{tokscan_pkg::K_ERROR, tokscan_pkg::E_INVALID,
                             tokscan_pkg::NO_WORD, c, tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
          end
          n = n + 3'd1;
        end
      end
    end

    if (off_nxt < OFF_MAX) off_nxt = off_nxt + 1'b1;
    if (c == 8'h0A) begin
      if (line_nxt < POS_MAX) line_nxt = line_nxt + 1'b1;
      col_nxt = POS_ONE;
    end else if (col_nxt < POS_MAX) begin
      col_nxt = col_nxt + 1'b1;
    end

    // End of text closes the pending token, reports the end and restarts.
    if (eot_i) begin
      case (mode_nxt)
        tokscan_pkg::M_WORD: begin
          cand[n[1:0]] = '{tokscan_pkg::word_lookup(wbuf_nxt, wlen_nxt) == tokscan_pkg::NO_WORD
                             ? tokscan_pkg::K_IDENT
                             : (tokscan_pkg::word_lookup(wbuf_nxt, wlen_nxt) < 4'd6
                                ? tokscan_pkg::K_KEYWORD : tokscan_pkg::K_BOOL),
                           tokscan_pkg::E_NONE, tokscan_pkg::word_lookup(wbuf_nxt, wlen_nxt),
                           tokscan_pkg::OP_NONE, tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
          n = n + 3'd1;
        end
        tokscan_pkg::M_NUMBER: begin
          cand[n[1:0]] = '{dot_nxt ? tokscan_pkg::K_FLOAT : tokscan_pkg::K_INT,
                           tokscan_pkg::E_NONE, tokscan_pkg::NO_WORD, tokscan_pkg::OP_NONE,
                           tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
          n = n + 3'd1;
        end
        tokscan_pkg::M_AFTERDOT: begin
          cand[n[1:0]] = '{tokscan_pkg::K_FLOAT, tokscan_pkg::E_NONE, tokscan_pkg::NO_WORD,
                           tokscan_pkg::OP_NONE, tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
          n = n + 3'd1;
        end
        tokscan_pkg::M_BADIDENT: begin
          cand[n[1:0]] = '{tokscan_pkg::K_ERROR, tokscan_pkg::E_BADIDENT,
                           tokscan_pkg::NO_WORD, tokscan_pkg::OP_NONE,
                           tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
          n = n + 3'd1;
        end
        tokscan_pkg::M_STRING, tokscan_pkg::M_ESCAPE: begin
          cand[n[1:0]] = '{tokscan_pkg::K_ERROR, tokscan_pkg::E_UNCLOSED,
                           tokscan_pkg::NO_WORD, tokscan_pkg::OP_NONE,
                           tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
          n = n + 3'd1;
        end
        tokscan_pkg::M_AMP: begin
          cand[n[1:0]] = '{tokscan_pkg::K_ERROR, tokscan_pkg::E_UNKNOWN,
                           tokscan_pkg::NO_WORD, 8'h26, tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
          n = n + 3'd1;
        end
        tokscan_pkg::M_PLUS: begin
          cand[n[1:0]] = '{tokscan_pkg::K_OPERATOR, tokscan_pkg::E_NONE,
                           tokscan_pkg::NO_WORD, 8'h2B, tso_nxt, tlen_nxt, tsl_nxt, tsc_nxt};
          n = n + 3'd1;
        end
        default: ;
      endcase
      // Only three results fit one step; a fourth end marker is dropped.
      cand[n[1:0]] = '{tokscan_pkg::K_END, tokscan_pkg::E_NONE, tokscan_pkg::NO_WORD,
                       tokscan_pkg::OP_NONE, off_nxt, '0, line_nxt, col_nxt};
      n = n + 3'd1;
      mode_nxt = tokscan_pkg::M_IDLE;
      dot_nxt = 1'b0;  off_nxt = '0;  line_nxt = POS_ONE;  col_nxt = POS_ONE;
      tso_nxt = '0;    tsl_nxt = POS_ONE;  tsc_nxt = POS_ONE;
      wbuf_nxt = '0;   wlen_nxt = '0;  tlen_nxt = '0;
    end
  end

  always_comb begin
    bundle.cnt    = (n > 3'd3) ? 2'd3 : n[1:0];
    bundle.res[0] = cand[0];
    bundle.res[1] = cand[1];
    bundle.res[2] = cand[2];
  end

  assign push_o   = take_i && (n != 3'd0);
  assign bundle_o = bundle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tokscan_pkg::M_IDLE;
      dot_r  <= 1'b0;
      off_r  <= '0;
      line_r <= POS_ONE;
      col_r  <= POS_ONE;
      tso_r  <= '0;
      tsl_r  <= POS_ONE;
      tsc_r  <= POS_ONE;
      tlen_r <= '0;
      wbuf_r <= '0;
      wlen_r <= '0;
    end else if (take_i) begin
      mode_r <= mode_nxt;
      dot_r  <= dot_nxt;
      off_r  <= off_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      tso_r  <= tso_nxt;
      tsl_r  <= tsl_nxt;
      tsc_r  <= tsc_nxt;
      tlen_r <= tlen_nxt;
      wbuf_r <= wbuf_nxt;
      wlen_r <= wlen_nxt;
    end
  end

endmodule

### sv/tok_queue.sv
// Small register queue that holds result bundles between the front and back ends.
module tok_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tokscan_pkg::QUEUE_DEPTH,
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);

  logic [WIDTH-1:0]  mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PTR_BITS:0] cnt_r, cnt_nxt;

  assign empty_o = (cnt_r == '0);
  assign full_o  = (cnt_r == (PTR_BITS+1)'(DEPTH));
  assign data_o  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push_i) wr_nxt = (wr_r == PTR_BITS'(DEPTH-1)) ? '0 : wr_r + 1'b1;
    if (pop_i)  rd_nxt = (rd_r == PTR_BITS'(DEPTH-1)) ? '0 : rd_r + 1'b1;
    if (push_i && !pop_i) cnt_nxt = cnt_r + 1'b1;
    else if (pop_i && !push_i) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_r] <= data_i;
  end

endmodule

### sv/tok_back.sv
// Back end: hands out the results of the head bundle one transfer at a time.
module tok_back #(
  parameter int OFFSET_BITS   = tokscan_pkg::OFFSET_BITS_DEF,
  parameter int POSITION_BITS = tokscan_pkg::POSITION_BITS_DEF,
  localparam int RES_BITS     = 19 + 2*OFFSET_BITS + 2*POSITION_BITS,
  localparam int BUNDLE_BITS  = 2 + 3*RES_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [BUNDLE_BITS-1:0] bundle_i,
  input  logic                   empty_i,
  output logic                   pop_o,
  tok_out_if.source              out_ch
);

  typedef struct packed {
    logic [3:0]               kind;
    logic [2:0]               err;
    logic [3:0]               word;
    logic [7:0]               op;
    logic [OFFSET_BITS-1:0]   off;
    logic [OFFSET_BITS-1:0]   len;
    logic [POSITION_BITS-1:0] line;
    logic [POSITION_BITS-1:0] col;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t [2:0] res;
  } bundle_t;

  bundle_t    head;
  res_t       cur;
  logic [1:0] idx_r, idx_nxt;
  logic       last, xfer;

  assign head = bundle_t'(bundle_i);
  assign cur  = (idx_r == 2'd0) ? head.res[0] : (idx_r == 2'd1 ? head.res[1] : head.res[2]);
  assign last = (idx_r == head.cnt - 2'd1);
  assign xfer = out_ch.valid && out_ch.ready;
  assign pop_o = xfer && last;

  assign out_ch.valid         = !empty_i;
  assign out_ch.token_kind    = cur.kind;
  assign out_ch.error_code    = cur.err;
  assign out_ch.word_index    = cur.word;
  assign out_ch.op_code       = cur.op;
  assign out_ch.start_offset  = cur.off;
  assign out_ch.lexeme_length = cur.len;
  assign out_ch.token_line    = cur.line;
  assign out_ch.token_column  = cur.col;
  assign out_ch.last_of_run   = last;

  always_comb begin
    idx_nxt = idx_r;
    if (xfer) idx_nxt = last ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= 2'd0;
    else        idx_r <= idx_nxt;
  end

endmodule

### sv/c_subset_token_scanner.sv
// Top level of the token scanner: front end, bundle queue and back end.
//
// Source bytes enter on in_ch, one per transfer, with end_of_text on the last
// byte of a text. Tokens leave on out_ch, one result per transfer; last_of_run
// marks the final result caused by one byte, and a kind-end result closes each
// text, after which the scanner starts the next text from line 1, column 1.
// A byte is scanned in the cycle it is transferred; its results enter the
// bundle queue and leave on out_ch one per cycle while the receiver is ready.
// A new byte is taken every cycle as long as the four-entry bundle queue is not
// full, so bytes that cause at most one result each run at one byte per cycle;
// a byte that causes two or three results holds the output for one transfer per
// result, which sets the sustained rate. When the receiver stalls, the queue
// absorbs up to four bundles before in_ch.ready drops. A synchronous reset empties
// the queue and returns every counter and the scan state to the start of a text.
module c_subset_token_scanner #(
  parameter int OFFSET_BITS   = tokscan_pkg::OFFSET_BITS_DEF,
  parameter int POSITION_BITS = tokscan_pkg::POSITION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tok_in_if.sink    in_ch,
  tok_out_if.source out_ch
);

  localparam int RES_BITS    = 19 + 2*OFFSET_BITS + 2*POSITION_BITS;
  localparam int BUNDLE_BITS = 2 + 3*RES_BITS;

  logic                   push, pop, empty, full, take;
  logic [BUNDLE_BITS-1:0] wdata, rdata;

  assign in_ch.ready = !full;
  assign take        = in_ch.valid && !full;

  tok_front #(.OFFSET_BITS(OFFSET_BITS), .POSITION_BITS(POSITION_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .take_i(take), .byte_i(in_ch.text_byte),
    .eot_i(in_ch.end_of_text), .push_o(push), .bundle_o(wdata)
  );

  tok_queue #(.WIDTH(BUNDLE_BITS), .DEPTH(tokscan_pkg::QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push_i(push), .data_i(wdata), .pop_i(pop),
    .data_o(rdata), .empty_o(empty), .full_o(full)
  );

  tok_back #(.OFFSET_BITS(OFFSET_BITS), .POSITION_BITS(POSITION_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .bundle_i(rdata), .empty_i(empty), .pop_o(pop),
    .out_ch(out_ch)
  );

endmodule

### sv/tok_checker.sv
// Port checker for the token scanner, bound to the top level.
module tok_checker #(
  parameter int OFFSET_BITS = tokscan_pkg::OFFSET_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [3:0]             token_kind,
  input logic [2:0]             error_code,
  input logic [3:0]             word_index,
  input logic [OFFSET_BITS-1:0] lexeme_length,
  input logic                   last_of_run
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(lexeme_length))
    else $error("stalled result changed");

  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && token_kind == tokscan_pkg::K_END |->
      last_of_run && lexeme_length == '0 && word_index == tokscan_pkg::NO_WORD)
    else $error("malformed end result");

  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((error_code != tokscan_pkg::E_NONE) == (token_kind == tokscan_pkg::K_ERROR)))
    else $error("error code disagrees with kind");

endmodule

bind c_subset_token_scanner tok_checker #(.OFFSET_BITS(OFFSET_BITS)) u_tok_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .token_kind(out_ch.token_kind), .error_code(out_ch.error_code),
  .word_index(out_ch.word_index), .lexeme_length(out_ch.lexeme_length),
  .last_of_run(out_ch.last_of_run)
);

### tb/sv/tokscan_checker.sv
`timescale 1ns / 100ps
// Checker of the token scanner: predicts the token stream and compares every transfer.
module tokscan_checker (
  input  logic clk,
  input  logic rst_n,
  tok_in_if    in_mon,
  tok_out_if   out_mon,
  output int   fail_count,
  output int   pending
);
  import tokscan_pkg::*;

  localparam int OB = OFFSET_BITS_DEF;
  localparam int PB = POSITION_BITS_DEF;

  typedef struct packed {
    logic [3:0]    kind;
    logic [2:0]    err;
    logic [3:0]    word;
    logic [7:0]    op;
    logic [OB-1:0] off;
    logic [OB-1:0] len;
    logic [PB-1:0] line;
    logic [PB-1:0] col;
    logic          last;
  } token_t;

  const string word_list [10] = '{"int", "char", "return", "if", "else", "for",
                                  "true", "false", "True", "False"};

  token_t        expected_tokens [$];
  token_t        byte_tokens [$];
  scan_mode_t    mode;
  logic          dot_seen;
  logic [OB-1:0] pos_off, tok_off, tok_len;
  logic [PB-1:0] pos_line, pos_col, tok_line, tok_col;
  logic [47:0]   wbuf;
  logic [2:0]    wlen;

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit starts_word(logic [7:0] c);
    return is_letter(c) || c == "_";
  endfunction
  function automatic bit in_word(logic [7:0] c);
    return is_letter(c) || is_num(c) || c == "_";
  endfunction

  task automatic clear_scanner();
    mode = M_IDLE;  dot_seen = 0;
    pos_off = '0;   pos_line = 1;  pos_col = 1;
    tok_off = '0;   tok_line = 1;  tok_col = 1;
    tok_len = '0;   wbuf = '0;     wlen = '0;
  endtask

  task automatic put_token(logic [3:0] k, logic [2:0] e, logic [3:0] w, logic [7:0] o,
                           logic [OB-1:0] off, logic [OB-1:0] len,
                           logic [PB-1:0] ln, logic [PB-1:0] col);
    token_t t;
    t = '{k, e, w, o, off, len, ln, col, 1'b0};
    if (byte_tokens.size() < 3) byte_tokens.insert(byte_tokens.size(), t);
  endtask

  task automatic close_token(logic [3:0] k, logic [2:0] e, logic [3:0] w, logic [7:0] o);
    put_token(k, e, w, o, tok_off, tok_len, tok_line, tok_col);
  endtask

  task automatic grow_token();
    if (tok_len != '1) tok_len++;
  endtask

  task automatic add_letter(logic [7:0] c);
    if (wlen < 6) wbuf = {wbuf[39:0], c};
    if (wlen < 7) wlen++;
  endtask

  task automatic close_word();
    logic [47:0] p;
    for (int w = 0; w < 10; w++) begin
      p = '0;
      for (int k = 0; k < word_list[w].len(); k++) p = {p[39:0], word_list[w][k]};
      if (word_list[w].len() == wlen && p == wbuf) begin
        close_token(w < 6 ? K_KEYWORD : K_BOOL, E_NONE, 4'(w), OP_NONE);
        return;
      end
    end
    close_token(K_IDENT, E_NONE, NO_WORD, OP_NONE);
  endtask

  // Continues the open token; taken is low when the byte must start a new one.
  task automatic continue_token(logic [7:0] c, output bit taken);
    taken = 0;
    case (mode)
      M_DIRECTIVE: begin
        if (c == 8'h0A) mode = M_IDLE;
        else taken = 1;
      end
      M_WORD: begin
        if (in_word(c)) begin
          grow_token(); add_letter(c); taken = 1;
        end else begin
          close_word(); mode = M_IDLE;
        end
      end
      M_NUMBER: begin
        if (is_num(c)) begin
          grow_token(); taken = 1;
        end else if (c == ".") begin
          grow_token(); taken = 1;
          if (dot_seen) begin
            close_token(K_ERROR, E_DOT, NO_WORD, OP_NONE); mode = M_AFTERDOT;
          end else dot_seen = 1;
        end else if (starts_word(c)) begin
          grow_token(); mode = M_BADIDENT; taken = 1;
        end else begin
          close_token(dot_seen ? K_FLOAT : K_INT, E_NONE, NO_WORD, OP_NONE);
          mode = M_IDLE;
        end
      end
      M_AFTERDOT: begin
        if (starts_word(c)) begin
          grow_token(); mode = M_BADIDENT; taken = 1;
        end else begin
          close_token(K_FLOAT, E_NONE, NO_WORD, OP_NONE); mode = M_IDLE;
        end
      end
      M_BADIDENT: begin
        if (in_word(c)) begin
          grow_token(); taken = 1;
        end else begin
          close_token(K_ERROR, E_BADIDENT, NO_WORD, OP_NONE); mode = M_IDLE;
        end
      end
      M_STRING: begin
        grow_token(); taken = 1;
        if (c == "\\") mode = M_ESCAPE;
        else if (c == "\"") begin
          close_token(K_STRING, E_NONE, NO_WORD, OP_NONE); mode = M_IDLE;
        end
      end
      M_ESCAPE: begin
        grow_token(); mode = M_STRING; taken = 1;
      end
      M_AMP: begin
        if (c == "&") begin
          grow_token(); close_token(K_OPERATOR, E_NONE, NO_WORD, OP_ANDAND);
          taken = 1;
        end else close_token(K_ERROR, E_UNKNOWN, NO_WORD, "&");
        mode = M_IDLE;
      end
      M_PLUS: begin
        if (c == "+") begin
          grow_token(); close_token(K_OPERATOR, E_NONE, NO_WORD, OP_PLUSPLUS);
          taken = 1;
        end else close_token(K_OPERATOR, E_NONE, NO_WORD, "+");
        mode = M_IDLE;
      end
      default: mode = M_IDLE;
    endcase
  endtask

  task automatic open_token(logic [7:0] c);
    tok_off = pos_off;  tok_line = pos_line;  tok_col = pos_col;
    tok_len = '0;  dot_seen = 0;  wbuf = '0;  wlen = '0;
    if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) return;
    if (c == "#") begin
      mode = M_DIRECTIVE;
      return;
    end
    grow_token();
    if (starts_word(c)) begin
      add_letter(c); mode = M_WORD;
    end else if (is_num(c)) mode = M_NUMBER;
    else if (c == "\"") mode = M_STRING;
    else if (c == "&") mode = M_AMP;
    else if (c == "+") mode = M_PLUS;
    else if (c == "=" || c == ">" || c == "<")
      close_token(K_OPERATOR, E_NONE, NO_WORD, c);
    else if (c == "|" || c == "!" || c == ":" || c == "%" || c == "^")
      close_token(K_ERROR, E_UNKNOWN, NO_WORD, c);
    else if (c == "(" || c == ")" || c == "{" || c == "}" || c == "[" || c == "]" ||
             c == "," || c == ";")
      close_token(K_DELIM, E_NONE, NO_WORD, c);
    else close_token(K_ERROR, E_INVALID, NO_WORD, c);
  endtask

  task automatic close_text();
    case (mode)
      M_WORD:             close_word();
      M_NUMBER:           close_token(dot_seen ? K_FLOAT : K_INT, E_NONE, NO_WORD, OP_NONE);
      M_AFTERDOT:         close_token(K_FLOAT, E_NONE, NO_WORD, OP_NONE);
      M_BADIDENT:         close_token(K_ERROR, E_BADIDENT, NO_WORD, OP_NONE);
      M_STRING, M_ESCAPE: close_token(K_ERROR, E_UNCLOSED, NO_WORD, OP_NONE);
      M_AMP:              close_token(K_ERROR, E_UNKNOWN, NO_WORD, "&");
      M_PLUS:             close_token(K_OPERATOR, E_NONE, NO_WORD, "+");
      default: ;
    endcase
    put_token(K_END, E_NONE, NO_WORD, OP_NONE, pos_off, '0, pos_line, pos_col);
    clear_scanner();
  endtask

  task automatic scan_byte(logic [7:0] c, logic eot);
    bit taken;
    byte_tokens.delete();
    continue_token(c, taken);
    if (!taken) open_token(c);
    if (pos_off != '1) pos_off++;
    if (c == 8'h0A) begin
      if (pos_line != '1) pos_line++;
      pos_col = 1;
    end else if (pos_col != '1) pos_col++;
    if (eot) close_text();
    if (byte_tokens.size() > 0) byte_tokens[$].last = 1;
    foreach (byte_tokens[i]) expected_tokens.insert(expected_tokens.size(), byte_tokens[i]);
  endtask

  initial begin
    fail_count = 0;
    clear_scanner();
  end

  assign pending = expected_tokens.size();

  // Inputs change only at rising edges, so a transfer seen at the falling edge
  // is certain to happen at the next rising edge.
  always @(negedge clk) begin
    token_t got, want;
    if (!rst_n) begin
      clear_scanner();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.token_kind, out_mon.error_code, out_mon.word_index,
                out_mon.op_code, out_mon.start_offset, out_mon.lexeme_length,
                out_mon.token_line, out_mon.token_column, out_mon.last_of_run};
        if (expected_tokens.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: unexpected token transfer %p", $realtime, got);
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: token mismatch\n  expected %p\n  actual   %p",
                       $realtime, want, got);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) scan_byte(in_mon.text_byte, in_mon.end_of_text);
    end
  end
endmodule

### tb/sv/c_subset_token_scanner_test.sv
`timescale 1ns / 100ps
// Top of the token scanner testbench: clock, reset, source text and output back-pressure.
module c_subset_token_scanner_test;
  logic clk = 0;
  logic rst_n = 0;
  bit   quiet = 0;
  bit   hold = 0;
  int   fail_count, pending;
  logic [8:0] text_q [$];

  tok_in_if  in_ch ();
  tok_out_if out_ch ();

  c_subset_token_scanner uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  tokscan_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
                       .fail_count(fail_count), .pending(pending));

  always #4 clk = ~clk;

  initial begin
    #3200000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic append_byte(logic [8:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) append_byte({1'b0, s[i]});
  endtask

  task automatic add_random_fragment();
    string words [12] = '{"int", "char", "return", "if", "else", "for", "true", "false",
                          "True", "False", "returns", "Tru"};
    string ops [7]    = '{"&&", "++", "&", "+", "=", ">", "<"};
    string delims     = "(){}[],;";
    string bad_ops    = "|!:%^";
    string blanks     = " \t\r\n";
    string id_chars   = "abcxyzABQZ_019";
    int n;
    case ($urandom_range(0, 10))
      0, 1: add_text(words[$urandom_range(0, 11)]);
      2: begin
        add_text($urandom_range(0, 1) ? "_" : "v");
        n = $urandom_range(0, 8);
        repeat (n) append_byte({1'b0, id_chars[$urandom_range(0, 13)]});
      end
      3: begin
        repeat ($urandom_range(1, 3)) append_byte({1'b0, 8'($urandom_range(48, 57))});
        if ($urandom_range(0, 1)) add_text(".5");
        if ($urandom_range(0, 3) == 0) add_text(".7");
        if ($urandom_range(0, 4) == 0) add_text("e_2");
      end
      4: begin
        add_text("\"");
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 4) == 0) add_text($urandom_range(0, 1) ? "\\\"" : "\\\\");
          else append_byte({1'b0, 8'($urandom_range(32, 126))});
        end
        if ($urandom_range(0, 9) != 0) add_text("\"");
      end
      5: add_text(ops[$urandom_range(0, 6)]);
      6: append_byte({1'b0, delims[$urandom_range(0, 7)]});
      7: append_byte({1'b0, blanks[$urandom_range(0, 3)]});
      8: begin
        add_text("#");
        repeat ($urandom_range(0, 4)) append_byte({1'b0, 8'($urandom_range(32, 126))});
        add_text("\n");
      end
      9: append_byte({1'b0, 8'($urandom_range(0, 255))});
      default: append_byte({1'b0, bad_ops[$urandom_range(0, 4)]});
    endcase
    if ($urandom_range(0, 2) == 0) append_byte({1'b0, blanks[$urandom_range(0, 3)]});
    if ($urandom_range(0, 14) == 0) text_q[$][8] = 1'b1;
  endtask

  // Output side: random stalls, one long hold-off, none near the end.
  initial begin
    out_ch.ready = 0;
    forever begin
      if (hold) begin
        out_ch.ready <= 0;
        @(posedge clk);
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ch.ready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    wait (rst_n);
    repeat (150) @(posedge clk);
    hold = 1;
    repeat (120) @(posedge clk);
    hold = 0;
  end

  initial begin
    bit rdy;
    int total;
    in_ch.valid = 0;
    in_ch.text_byte = 0;
    in_ch.end_of_text = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // Directed text: keywords, number errors, escapes, operators, extreme bytes
    // and a string that closes on the last byte of a text.
    add_text("#x\nint Fals 1.2.3 7a_ \"q\\\"&e++ =|@");
    append_byte({1'b0, 8'h00});
    append_byte({1'b0, 8'hFF});
    append_byte({1'b1, "\""});
    add_text("1.2.k&&+(");
    text_q[$][8] = 1'b1;
    while (text_q.size() < 320) add_random_fragment();
    text_q[$][8] = 1'b1;

    total = text_q.size();
    foreach (text_q[i]) begin
      if (i >= total - 60) quiet = 1;
      if (!quiet && $urandom_range(0, 4) == 0) begin
        in_ch.valid <= 0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      in_ch.valid <= 1;
      in_ch.text_byte <= text_q[i][7:0];
      in_ch.end_of_text <= text_q[i][8];
      do begin
        @(negedge clk);
        rdy = in_ch.ready;
        @(posedge clk);
      end while (!rdy);
    end
    in_ch.valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
